>>> src/psev_pkg.sv
// Package for the postfix stack evaluator: stack sizing, status codes,
// command types and the character decoder.
// No dependencies.
package psev_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W       = 32;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic       push;
        logic       operate;
        alu_op_t    op;
        logic [3:0] digit;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        status_t          status;
    } result_t;

    function automatic cmd_t decode(input logic [7:0] symbol, input logic last);
        cmd_t       cmd;
        logic [7:0] offset;
        offset      = symbol - CHAR_ZERO;
        cmd.push    = (symbol >= CHAR_ZERO) && (symbol <= CHAR_NINE);
        cmd.operate = (symbol == CHAR_PLUS) || (symbol == CHAR_MINUS)
                   || (symbol == CHAR_STAR);
        if (symbol == CHAR_PLUS) begin
            cmd.op = OP_ADD;
        end else if (symbol == CHAR_MINUS) begin
            cmd.op = OP_SUB;
        end else begin
            cmd.op = OP_MUL;
        end
        cmd.digit = offset[3:0];
        cmd.last  = last;
        return cmd;
    endfunction

endpackage

>>> src/psev_alu.sv
// Arithmetic unit of the postfix stack evaluator: add, subtract or multiply
// of the two top stack entries, 32-bit wrapping. Depends on psev_pkg.
module psev_alu
    import psev_pkg::*;
(
    input  alu_op_t          op,
    input  logic [VAL_W-1:0] a,
    input  logic [VAL_W-1:0] b,
    output logic [VAL_W-1:0] r
);

    always_comb begin
        unique case (op)
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MUL:  r = a * b;
            default: r = a * b;
        endcase
    end

endmodule

>>> src/psev_stack.sv
// Value stack of the postfix stack evaluator: shift-register stack with the
// top at entry 0, entry count, sticky error and end-of-expression summary.
// Depends on psev_pkg.
module psev_stack
    import psev_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  cmd_t             cmd,
    input  logic [VAL_W-1:0] alu_r,
    output logic [VAL_W-1:0] top_a,
    output logic [VAL_W-1:0] top_b,
    output result_t          summary
);

    logic [VAL_W-1:0] stk_reg  [STACK_DEPTH];
    logic [VAL_W-1:0] stk_next [STACK_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next, count_upd;
    status_t          err_reg, err_next, err_upd;
    logic             full, can_op, push_ok, op_ok;

    assign full    = (count_reg == CNT_W'(STACK_DEPTH));
    assign can_op  = (count_reg >= CNT_W'(2));
    assign push_ok = cmd.push && !full;
    assign op_ok   = cmd.operate && can_op;

    // Entry 0 is the later operand, entry 1 the earlier one.
    assign top_b = stk_reg[0];
    assign top_a = stk_reg[1];

    always_comb begin
        count_upd = count_reg + CNT_W'(push_ok) - CNT_W'(op_ok);
        if (err_reg != ST_OK) begin
            err_upd = err_reg;
        end else if (cmd.push && full) begin
            err_upd = ST_OVERFLOW;
        end else if (cmd.operate && !can_op) begin
            err_upd = ST_UNDERFLOW;
        end else begin
            err_upd = ST_OK;
        end
        count_next = cmd.last ? '0 : count_upd;
        err_next   = cmd.last ? ST_OK : err_upd;
    end

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_entry
        always_comb begin
            stk_next[i] = stk_reg[i];
            if (push_ok) begin
                if (i == 0) begin
                    stk_next[i] = VAL_W'(cmd.digit);
                end else begin
                    stk_next[i] = stk_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (op_ok) begin
                if (i == 0) begin
                    stk_next[i] = alu_r;
                end else if (i < STACK_DEPTH - 1) begin
                    stk_next[i] = stk_reg[(i < STACK_DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb begin
        summary.value = (count_upd == '0) ? '0 : stk_next[0];
        if (err_upd != ST_OK) begin
            summary.status = err_upd;
        end else if (count_upd == '0) begin
            summary.status = ST_EMPTY;
        end else begin
            summary.status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            err_reg   <= ST_OK;
        end else if (step) begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            stk_reg <= stk_next;
        end
    end

endmodule

>>> src/postfix_stack_evaluator.sv
// Postfix (RPN) expression evaluator. Characters arrive one item per cycle
// while the input is not stalled: '0'..'9' push a digit, '+', '-' and '*'
// replace the two top values by earlier op later (32-bit signed, wrapping),
// anything else is ignored. The item marked last yields one result: the top
// value and a status (ok, underflow, overflow, or no value left), after which
// stack and error clear. The last item passes from the input register, which
// feeds the stack, into the result register stage. A last item waits in the
// input register while the previous result has not been taken. The stack
// holds STACK_DEPTH entries as a shift register.
// Depends on psev_pkg, psev_alu and psev_stack.
module postfix_stack_evaluator
    import psev_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_symbol,
    input  logic                    s_last,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_value,
    output logic [1:0]              m_status
);

    cmd_t             in_cmd_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    logic             step;
    logic [VAL_W-1:0] top_a, top_b, alu_r;
    result_t          summary;

    // An item without last never waits for the result side.
    assign step    = in_valid_reg && (!in_cmd_reg.last || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg <= decode(s_symbol, s_last);
        end
    end

    psev_alu u_alu (
        .op (in_cmd_reg.op),
        .a  (top_a),
        .b  (top_b),
        .r  (alu_r)
    );

    psev_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cmd     (in_cmd_reg),
        .alu_r   (alu_r),
        .top_a   (top_a),
        .top_b   (top_b),
        .summary (summary)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && in_cmd_reg.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_cmd_reg.last) begin
            out_reg <= summary;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_value  = out_reg.value;
    assign m_status = out_reg.status;

endmodule

>>> src/psev_checker.sv
// Port-level checks for the postfix stack evaluator, attached to the top
// level by a bind statement. Depends on psev_pkg and postfix_stack_evaluator.
module psev_checker
    import psev_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [VAL_W-1:0] m_value,
    input logic [1:0]              m_status
);

    // A result that is not taken holds its value and status.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // With room on the result side the input side never stalls.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while result side had room");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY) |-> (m_value == '0))
        else $error("empty stack reported with nonzero value");

endmodule

bind postfix_stack_evaluator psev_checker u_psev_checker (.*);

>>> tb/sv/postfix_stack_evaluator_tb.sv
// Self-checking testbench for postfix_stack_evaluator: streams postfix expressions
// through the valid/ready input, predicts each result and compares it field by field.
// Depends on psev_pkg and the postfix_stack_evaluator RTL.
module postfix_stack_evaluator_tb;
    import psev_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF    = 5;
    localparam int          RESET_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 250;
    localparam int unsigned HOLD_CYCLES = 300;

    // Mirror of the evaluator plus the results it has yet to produce.
    class rpn_scoreboard;
        logic [VAL_W-1:0] operands [STACK_DEPTH];
        int unsigned      fill;
        status_t          held_error;
        result_t          pending_results [$];
        int unsigned      errors;

        function new();
            fill       = 0;
            held_error = ST_OK;
            errors     = 0;
        endfunction

        function void raise_error(status_t code);
            if (held_error == ST_OK) begin
                held_error = code;
            end
        endfunction

        function void accept_symbol(logic [7:0] sym, logic lst);
            logic [VAL_W-1:0] lhs;
            logic [VAL_W-1:0] rhs;
            logic [VAL_W-1:0] res;
            result_t          r;
            if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
                if (fill == STACK_DEPTH) begin
                    raise_error(ST_OVERFLOW);
                end else begin
                    operands[fill] = VAL_W'(sym - CHAR_ZERO);
                    fill++;
                end
            end else if (sym == CHAR_PLUS || sym == CHAR_MINUS || sym == CHAR_STAR) begin
                if (fill < 2) begin
                    raise_error(ST_UNDERFLOW);
                end else begin
                    // The top entry is the later operand.
                    rhs = operands[fill-1];
                    lhs = operands[fill-2];
                    case (sym)
                        CHAR_PLUS:  res = lhs + rhs;
                        CHAR_MINUS: res = lhs - rhs;
                        default:    res = lhs * rhs;
                    endcase
                    fill--;
                    operands[fill-1] = res;
                end
            end
            if (lst) begin
                r.value = (fill != 0) ? operands[fill-1] : '0;
                if (held_error != ST_OK) begin
                    r.status = held_error;
                end else if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_OK;
                end
                pending_results = {pending_results, r};
                fill       = 0;
                held_error = ST_OK;
            end
        endfunction

        function void check_result(logic [VAL_W-1:0] val, logic [1:0] st);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: value %0d, status %0d", $signed(val), st);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (val !== want.value) begin
                $error("value mismatch: expected %0d, got %0d",
                       $signed(want.value), $signed(val));
                errors++;
            end
            if (st !== want.status) begin
                $error("status mismatch: expected %0d, got %0d", want.status, st);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_valid  = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_symbol = 8'h00;
    logic                    s_last   = 1'b0;
    logic                    m_valid;
    logic                    m_ready  = 1'b0;
    logic signed [VAL_W-1:0] m_value;
    logic [1:0]              m_status;

    rpn_scoreboard sb = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;
    int unsigned cycle_count    = 0;
    logic [7:0]  expr_q [$];

    postfix_stack_evaluator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_symbol (s_symbol),
        .s_last   (s_last),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value),
        .m_status (m_status)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side: check accepted items, then pick next cycle's ready.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_value, m_status);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic bit is_active(logic [7:0] c);
        return (c >= CHAR_ZERO && c <= CHAR_NINE)
            || c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR;
    endfunction

    function automatic logic [7:0] noise_symbol();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (is_active(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_digit(bit mul_heavy);
        return mul_heavy ? CHAR_ZERO + 8'($urandom_range(9, 2))
                         : CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] pick_operator(bit mul_heavy);
        if (mul_heavy && $urandom_range(3) != 0) begin
            return CHAR_STAR;
        end
        case ($urandom_range(2))
            0:       return CHAR_PLUS;
            1:       return CHAR_MINUS;
            default: return CHAR_STAR;
        endcase
    endfunction

    function automatic void add_symbol(input logic [7:0] c);
        expr_q = {expr_q, c};
    endfunction

    task automatic add_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            add_symbol(txt[i]);
        end
    endtask

    // Mostly well-formed expressions; the rest overflow the stack, are random
    // character soup or hold a single symbol.
    task automatic make_expression();
        int unsigned flavor;
        int unsigned pushes;
        int unsigned depth;
        int unsigned target;
        bit          mul_heavy;
        expr_q.delete();
        flavor = $urandom_range(99);
        if (flavor < 70) begin
            pushes    = ($urandom_range(9) == 0) ? $urandom_range(40, 16)
                                                 : $urandom_range(8, 1);
            mul_heavy = ($urandom_range(3) == 0);
            target    = ($urandom_range(9) == 0) ? 2 : 1;
            depth     = 0;
            while (pushes > 0 || depth > target) begin
                if ($urandom_range(9) == 0) begin
                    add_symbol(noise_symbol());
                end
                if (pushes > 0 && (depth < 2
                        || (depth < STACK_DEPTH && $urandom_range(1) == 0))) begin
                    add_symbol(pick_digit(mul_heavy));
                    pushes--;
                    depth++;
                end else begin
                    add_symbol(pick_operator(mul_heavy));
                    depth--;
                end
            end
            if ($urandom_range(9) == 0) begin
                add_symbol(noise_symbol());
            end
        end else if (flavor < 80) begin
            repeat ($urandom_range(20, STACK_DEPTH + 1)) add_symbol(pick_digit(0));
            repeat ($urandom_range(3)) add_symbol(pick_operator(0));
        end else if (flavor < 92) begin
            repeat ($urandom_range(12, 1)) begin
                case ($urandom_range(2))
                    0:       add_symbol(pick_digit(0));
                    1:       add_symbol(pick_operator(0));
                    default: add_symbol(noise_symbol());
                endcase
            end
        end else begin
            case ($urandom_range(2))
                0:       add_symbol(noise_symbol());
                1:       add_symbol(pick_operator(0));
                default: add_symbol(pick_digit(0));
            endcase
        end
    endtask

    // Valid stays high across back-to-back items; it only drops for idle cycles.
    task automatic send_item(input logic [7:0] sym, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_symbol <= sym;
        s_last   <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.accept_symbol(sym, lst);
    endtask

    task automatic send_expression(inout int unsigned active_count);
        foreach (expr_q[i]) begin
            send_item(expr_q[i], i == expr_q.size() - 1);
            if (is_active(expr_q[i])) begin
                active_count++;
            end
        end
    endtask

    // Sender goes quiet until every predicted result has been seen.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned sent;
        sent           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < PHASE_ITEMS) begin
            make_expression();
            send_expression(sent);
        end
        drain();
    endtask

    initial begin
        int unsigned sent;
        sent = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Underflow first, then evaluation carries on under the held error.
        expr_q = {8'h00};
        add_text("+5");
        send_expression(sent);
        // Nothing pushed at all.
        expr_q = {8'hFF};
        send_expression(sent);
        // Earlier minus later, negative product, two entries left at the end.
        expr_q.delete();
        add_text("735-4*6+");
        send_expression(sent);
        // One digit too many, then an operator still evaluated.
        expr_q.delete();
        repeat (STACK_DEPTH + 1) add_symbol(CHAR_NINE);
        add_symbol(CHAR_STAR);
        send_expression(sent);
        drain();

        // Long receiver hold-off while single-digit expressions keep coming.
        hold_left = HOLD_CYCLES;
        repeat (40) begin
            expr_q = {pick_digit(0)};
            send_expression(sent);
        end
        drain();

        run_phase(0, 0);
        run_phase(58, 0);
        run_phase(0, 58);
        run_phase(21, 21);

        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> files.f
src/psev_pkg.sv
src/psev_alu.sv
src/psev_stack.sv
src/postfix_stack_evaluator.sv
src/psev_checker.sv
tb/sv/postfix_stack_evaluator_tb.sv
